@@ rtl/core/midi_note_priority_cc_decoder_top_defines.svh @@
// ----------------------------------------------------------------------------
// MIDI note priority / CC decoder - assertion macros
// Shared concurrent assertion forms, synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef MIDI_NOTE_PRIORITY_CC_DECODER_TOP_DEFINES_SVH
`define MIDI_NOTE_PRIORITY_CC_DECODER_TOP_DEFINES_SVH

// same-cycle implication
`define MNPD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mnpd: assertion failed");

// next-cycle implication
`define MNPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mnpd: assertion failed");

`endif

@@ rtl/core/mnpd_pkg.sv @@
// ----------------------------------------------------------------------------
// mnpd_pkg
// Types, constants and the CC scaling function of the note priority decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package mnpd_pkg;

    localparam int NOTE_W = 7;
    localparam int NOTES  = 1 << NOTE_W;
    localparam int LVL_W  = 10;
    localparam int CHAN_W = 4;
    localparam int CTRL_W = 7;
    localparam int DATA_W = 7;

    localparam logic [3:0] MSG_NOTE_OFF = 4'h8;
    localparam logic [3:0] MSG_NOTE_ON  = 4'h9;
    localparam logic [3:0] MSG_CC       = 4'hB;

    localparam logic [1:0] PKT_FULL = 2'd3;

    localparam logic [CTRL_W-1:0] SECOND_CTRL_RESET = 7'd1;

    localparam int DATA_MAX = 127;

    typedef enum logic [1:0] {
        REG_CHANNEL     = 2'd0,
        REG_FIRST_CTRL  = 2'd1,
        REG_SECOND_CTRL = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic              command;
        logic [1:0]        packet_length;
        logic [7:0]        status_byte;
        logic [DATA_W-1:0] data_first;
        logic [DATA_W-1:0] data_second;
    } t_item;

    typedef struct packed {
        logic              found;
        logic [NOTE_W-1:0] note;
    } t_pick;

    // floor(v*1023/127) = 8v + floor(7v/127)
    function automatic logic [LVL_W-1:0] scale_level(input logic [DATA_W-1:0] v);
        logic [LVL_W-1:0] seven_v;
        logic [2:0]       q;
        seven_v = {v, 3'b000} - {3'b000, v};
        q = 3'd0;
        for (int k = 1; k < 8; k++) begin
            if (seven_v >= LVL_W'(DATA_MAX * k)) begin
                q = q + 3'd1;
            end
        end
        return {v, 3'b000} + {7'b0, q};
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/mnpd_prio_enc.sv @@
// ----------------------------------------------------------------------------
// mnpd_prio_enc
// Highest-set-bit encoder over the held-note vector, balanced binary tree.
// ----------------------------------------------------------------------------
`default_nettype none

module mnpd_prio_enc (
    input  wire logic [mnpd_pkg::NOTES-1:0] i_bits,
    output mnpd_pkg::t_pick                 o_pick
);
    import mnpd_pkg::*;

    localparam int INNER = NOTES - 1;
    localparam int NODES = 2 * NOTES - 1;

    logic [NODES-1:0]  w_found;
    logic [NOTE_W-1:0] w_idx [NODES];

    // leaves in ascending note order, right child holds the higher notes
    for (genvar g = 0; g < NOTES; g++) begin : g_leaf
        assign w_found[INNER+g] = i_bits[g];
        assign w_idx[INNER+g]   = NOTE_W'(g);
    end

    for (genvar k = 0; k < INNER; k++) begin : g_node
        assign w_found[k] = w_found[2*k+1] | w_found[2*k+2];
        assign w_idx[k]   = w_found[2*k+2] ? w_idx[2*k+2] : w_idx[2*k+1];
    end

    assign o_pick.found = w_found[0];
    assign o_pick.note  = w_idx[0];

endmodule

`default_nettype wire

@@ rtl/core/midi_note_priority_cc_decoder_top.sv @@
// ----------------------------------------------------------------------------
// midi_note_priority_cc_decoder_top
// MIDI highest-note-priority decoder with two scaled controller levels.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) carries one message or removal
// event per word; output channel (o_out_valid / i_out_ready) returns one
// result word per input word: both levels, current note, any-held flag.
// The input register loads at the accepting edge; the state and result
// registers load from it when the output is free, raising o_out_valid.
// Throughput: one word per cycle without stalls; the held-note update and
// the 128-way priority encoder are combinational between the two registers.
// When the receiver stalls, the result holds and the input register still
// takes one more word; o_in_ready drops only when both are full.
// Reset (synchronous, active low) clears held notes, levels and note to
// zero, the listen channel to 0 and the controllers to 0 and 1.
// Configuration: APB, listen channel at 0x0, first controller at 0x4,
// second controller at 0x8; write only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "midi_note_priority_cc_decoder_top_defines.svh"

module midi_note_priority_cc_decoder_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,

    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [3:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,

    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_command,
    input  wire logic [1:0]                    i_packet_length,
    input  wire logic [7:0]                    i_status_byte,
    input  wire logic [mnpd_pkg::DATA_W-1:0]   i_data_first,
    input  wire logic [mnpd_pkg::DATA_W-1:0]   i_data_second,

    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [mnpd_pkg::LVL_W-1:0]         o_first_level,
    output logic [mnpd_pkg::LVL_W-1:0]         o_second_level,
    output logic [mnpd_pkg::NOTE_W-1:0]        o_current_note,
    output logic                               o_any_held
);
    import mnpd_pkg::*;

    // configuration
    logic [CHAN_W-1:0] r_channel;
    logic [CTRL_W-1:0] r_first_ctrl;
    logic [CTRL_W-1:0] r_second_ctrl;
    logic              w_cfg_wr;

    // input register
    t_item r_in;
    logic  r_in_valid;
    logic  n_in_valid;

    // state / result
    logic [NOTES-1:0]  r_held;
    logic [NOTES-1:0]  n_held;
    logic [LVL_W-1:0]  r_first_lvl;
    logic [LVL_W-1:0]  n_first_lvl;
    logic [LVL_W-1:0]  r_second_lvl;
    logic [LVL_W-1:0]  n_second_lvl;
    logic [NOTE_W-1:0] r_note;
    logic [NOTE_W-1:0] n_note;
    logic              r_any_held;
    logic              r_out_valid;
    logic              n_out_valid;

    logic              w_accept;
    logic              w_adv;
    logic              w_fire;
    logic              w_msg;
    logic              w_cc;
    logic              w_note_on;
    logic              w_note_off;
    logic [LVL_W-1:0]  w_level;
    t_pick             w_pick;

    // ---------------- configuration port ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel     <= '0;
            r_first_ctrl  <= '0;
            r_second_ctrl <= SECOND_CTRL_RESET;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                REG_CHANNEL:     r_channel     <= pwdata[CHAN_W-1:0];
                REG_FIRST_CTRL:  r_first_ctrl  <= pwdata[CTRL_W-1:0];
                REG_SECOND_CTRL: r_second_ctrl <= pwdata[CTRL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_CHANNEL:     prdata = {{(32-CHAN_W){1'b0}}, r_channel};
            REG_FIRST_CTRL:  prdata = {{(32-CTRL_W){1'b0}}, r_first_ctrl};
            REG_SECOND_CTRL: prdata = {{(32-CTRL_W){1'b0}}, r_second_ctrl};
            default:         prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    assign w_adv      = !r_out_valid || i_out_ready;
    assign w_fire     = r_in_valid && w_adv;
    assign o_in_ready = !r_in_valid || w_adv;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_accept) begin
            n_in_valid = 1'b1;
        end else if (w_fire) begin
            n_in_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_fire) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in.command       <= i_command;
            r_in.packet_length <= i_packet_length;
            r_in.status_byte   <= i_status_byte;
            r_in.data_first    <= i_data_first;
            r_in.data_second   <= i_data_second;
        end
    end

    // ---------------- decode and update ----------------
    assign w_msg      = !r_in.command && (r_in.packet_length == PKT_FULL)
                        && (r_in.status_byte[3:0] == r_channel);
    assign w_cc       = w_msg && (r_in.status_byte[7:4] == MSG_CC);
    assign w_note_on  = w_msg && (r_in.status_byte[7:4] == MSG_NOTE_ON)
                        && (r_in.data_second != '0);
    assign w_note_off = w_msg && ((r_in.status_byte[7:4] == MSG_NOTE_OFF)
                        || ((r_in.status_byte[7:4] == MSG_NOTE_ON)
                            && (r_in.data_second == '0)));
    assign w_level    = scale_level(r_in.data_second);

    always_comb begin
        priority if (r_in.command) begin
            n_held = '0;
        end else if (w_note_on) begin
            n_held = r_held | (NOTES'(1) << r_in.data_first);
        end else if (w_note_off) begin
            n_held = r_held & ~(NOTES'(1) << r_in.data_first);
        end else begin
            n_held = r_held;
        end
    end

    mnpd_prio_enc u_prio_enc (
        .i_bits (n_held),
        .o_pick (w_pick)
    );

    always_comb begin
        n_note = r_note;
        if ((w_note_on || w_note_off) && w_pick.found) begin
            n_note = w_pick.note;
        end
        n_first_lvl  = r_first_lvl;
        n_second_lvl = r_second_lvl;
        if (w_cc && (r_in.data_first == r_first_ctrl)) begin
            n_first_lvl = w_level;
        end
        if (w_cc && (r_in.data_first == r_second_ctrl)) begin
            n_second_lvl = w_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held       <= '0;
            r_first_lvl  <= '0;
            r_second_lvl <= '0;
            r_note       <= '0;
            r_any_held   <= 1'b0;
        end else if (w_fire) begin
            r_held       <= n_held;
            r_first_lvl  <= n_first_lvl;
            r_second_lvl <= n_second_lvl;
            r_note       <= n_note;
            r_any_held   <= w_pick.found;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_first_level  = r_first_lvl;
    assign o_second_level = r_second_lvl;
    assign o_current_note = r_note;
    assign o_any_held     = r_any_held;

    // ---------------- assertions ----------------
    `MNPD_ASSERT_IMPL(a_any_held_matches, i_clk, i_rst_n, 1'b1, r_any_held == (|r_held))
    `MNPD_ASSERT_IMPL(a_note_is_highest, i_clk, i_rst_n, r_any_held, (r_held >> r_note) == NOTES'(1))
    `MNPD_ASSERT_NEXT(a_fire_gives_result, i_clk, i_rst_n, w_fire, r_out_valid)

endmodule

`default_nettype wire

@@ dv/midi_note_priority_cc_decoder_top_tb.sv @@
// ----------------------------------------------------------------------------
// midi_note_priority_cc_decoder_top_tb
// Self-checking bench for the MIDI note priority / CC decoder. Directed words
// cover note priority, removal, controller scaling and ignored messages; then
// random traffic runs under several register settings and idle patterns. A
// local model of held notes and levels predicts every result word in order.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_note_priority_cc_decoder_top_tb;
    import mnpd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [LVL_W-1:0]  first_level;
        logic [LVL_W-1:0]  second_level;
        logic [NOTE_W-1:0] current_note;
        logic              any_held;
    } t_decoded;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [3:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    logic                i_in_valid;
    logic                o_in_ready;
    logic                i_command;
    logic [1:0]          i_packet_length;
    logic [7:0]          i_status_byte;
    logic [DATA_W-1:0]   i_data_first;
    logic [DATA_W-1:0]   i_data_second;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [LVL_W-1:0]    o_first_level;
    logic [LVL_W-1:0]    o_second_level;
    logic [NOTE_W-1:0]   o_current_note;
    logic                o_any_held;

    // model of the decoder state and its registers
    logic [NOTES-1:0]    mdl_held;
    logic [LVL_W-1:0]    mdl_first_level;
    logic [LVL_W-1:0]    mdl_second_level;
    logic [NOTE_W-1:0]   mdl_note;
    logic [CHAN_W-1:0]   cfg_channel;
    logic [CTRL_W-1:0]   cfg_first_ctrl;
    logic [CTRL_W-1:0]   cfg_second_ctrl;

    t_decoded            decoded_q[$];
    t_decoded            head_word;
    int                  error_count;
    int                  cycle_count;
    int                  send_idle_pct;
    int                  recv_stall_pct;

    midi_note_priority_cc_decoder_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_command       (i_command),
        .i_packet_length (i_packet_length),
        .i_status_byte   (i_status_byte),
        .i_data_first    (i_data_first),
        .i_data_second   (i_data_second),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_first_level   (o_first_level),
        .o_second_level  (o_second_level),
        .o_current_note  (o_current_note),
        .o_any_held      (o_any_held)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            error_count++;
        end
    endfunction

    // apply one accepted word to the model and queue the decoded state
    function automatic void track_midi_word(t_item w);
        int       lv;
        t_decoded r;
        logic     is_note;
        if (w.command) begin
            mdl_held = '0;
        end else if (w.packet_length == PKT_FULL && w.status_byte[3:0] == cfg_channel) begin
            is_note = 1'b0;
            if (w.status_byte[7:4] == MSG_CC) begin
                lv = int'(w.data_second) * 1023 / DATA_MAX;
                if (w.data_first == cfg_first_ctrl) begin
                    mdl_first_level = LVL_W'(lv);
                end
                if (w.data_first == cfg_second_ctrl) begin
                    mdl_second_level = LVL_W'(lv);
                end
            end else if (w.status_byte[7:4] == MSG_NOTE_ON && w.data_second != '0) begin
                mdl_held[w.data_first] = 1'b1;
                is_note = 1'b1;
            end else if (w.status_byte[7:4] == MSG_NOTE_OFF
                         || w.status_byte[7:4] == MSG_NOTE_ON) begin
                mdl_held[w.data_first] = 1'b0;
                is_note = 1'b1;
            end
            if (is_note) begin
                for (int n = NOTES - 1; n >= 0; n--) begin
                    if (mdl_held[n]) begin
                        mdl_note = NOTE_W'(n);
                        break;
                    end
                end
            end
        end
        r.first_level  = mdl_first_level;
        r.second_level = mdl_second_level;
        r.current_note = mdl_note;
        r.any_held     = |mdl_held;
        decoded_q.push_back(r);
    endfunction

    function automatic t_item mk(logic cmd, logic [1:0] len, logic [7:0] status,
                                 logic [6:0] d1, logic [6:0] d2);
        t_item w;
        w.command       = cmd;
        w.packet_length = len;
        w.status_byte   = status;
        w.data_first    = d1;
        w.data_second   = d2;
        return w;
    endfunction

    // mostly well-formed traffic on the listened channel
    function automatic t_item random_word();
        t_item      w;
        logic [3:0] typ;
        logic [3:0] chan;
        int         pick;
        w.command       = ($urandom_range(99) < 3);
        w.packet_length = ($urandom_range(99) < 88) ? PKT_FULL : 2'($urandom_range(3));
        chan = ($urandom_range(99) < 88) ? cfg_channel : 4'($urandom);
        pick = $urandom_range(99);
        if (pick < 38) begin
            typ = MSG_NOTE_ON;
        end else if (pick < 60) begin
            typ = MSG_NOTE_OFF;
        end else if (pick < 88) begin
            typ = MSG_CC;
        end else begin
            typ = 4'($urandom);
        end
        w.status_byte = {typ, chan};
        pick = $urandom_range(99);
        if (typ == MSG_CC) begin
            w.data_first = (pick < 40) ? cfg_first_ctrl :
                           (pick < 80) ? cfg_second_ctrl : 7'($urandom);
        end else if (typ == MSG_NOTE_OFF && pick < 30) begin
            w.data_first = mdl_note;
        end else begin
            w.data_first = (pick < 65) ? 7'($urandom_range(56, 71)) : 7'($urandom);
        end
        pick = $urandom_range(99);
        w.data_second = (pick < 15) ? 7'd0 : (pick < 25) ? 7'd127 : 7'($urandom);
        return w;
    endfunction

    task automatic send_word(t_item w);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_command       <= w.command;
        i_packet_length <= w.packet_length;
        i_status_byte   <= w.status_byte;
        i_data_first    <= w.data_first;
        i_data_second   <= w.data_second;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        track_midi_word(w);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // write, then read back
    task automatic write_reg(t_reg_idx idx, logic [31:0] val);
        logic [31:0] exp_v;
        case (idx)
            REG_CHANNEL: begin
                cfg_channel = val[CHAN_W-1:0];
                exp_v = 32'(cfg_channel);
            end
            REG_FIRST_CTRL: begin
                cfg_first_ctrl = val[CTRL_W-1:0];
                exp_v = 32'(cfg_first_ctrl);
            end
            default: begin
                cfg_second_ctrl = val[CTRL_W-1:0];
                exp_v = 32'(cfg_second_ctrl);
            end
        endcase
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        check_field("prdata", exp_v, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_registers(logic [3:0] chan, logic [6:0] ctrl_a, logic [6:0] ctrl_b);
        drain();
        write_reg(REG_CHANNEL, 32'(chan));
        write_reg(REG_FIRST_CTRL, 32'(ctrl_a));
        write_reg(REG_SECOND_CTRL, 32'(ctrl_b));
    endtask

    task automatic test_note_priority();
        set_registers(4'd0, 7'd0, 7'd1);
        send_word(mk(1'b1, 2'd0, 8'hFF, 7'h7F, 7'h7F));
        send_word(mk(1'b0, PKT_FULL, {MSG_NOTE_ON, 4'h0}, 7'd0, 7'd127));
        send_word(mk(1'b0, PKT_FULL, {MSG_NOTE_ON, 4'h0}, 7'd127, 7'd1));
        send_word(mk(1'b0, PKT_FULL, {MSG_NOTE_ON, 4'h0}, 7'd64, 7'd64));
        send_word(mk(1'b0, PKT_FULL, {MSG_NOTE_OFF, 4'h0}, 7'd127, 7'd127));
        send_word(mk(1'b0, PKT_FULL, {MSG_NOTE_ON, 4'h0}, 7'd64, 7'd0));
        send_word(mk(1'b0, PKT_FULL, {MSG_NOTE_OFF, 4'h0}, 7'd0, 7'd0));
        send_word(mk(1'b0, PKT_FULL, {MSG_NOTE_ON, 4'h0}, 7'd100, 7'd5));
        send_word(mk(1'b0, PKT_FULL, {MSG_NOTE_OFF, 4'h0}, 7'd100, 7'd64));
        send_word(mk(1'b0, PKT_FULL, {MSG_NOTE_ON, 4'h0}, 7'd90, 7'd9));
        send_word(mk(1'b1, 2'd3, 8'h00, 7'd0, 7'd0));
        send_word(mk(1'b0, 2'd0, {MSG_NOTE_ON, 4'h0}, 7'd120, 7'd1));
        send_word(mk(1'b0, 2'd1, {MSG_NOTE_ON, 4'h0}, 7'd121, 7'd1));
        send_word(mk(1'b0, 2'd2, {MSG_NOTE_ON, 4'h0}, 7'd122, 7'd1));
        send_word(mk(1'b0, PKT_FULL, {MSG_NOTE_ON, 4'h1}, 7'd123, 7'd1));
        send_word(mk(1'b0, PKT_FULL, {MSG_NOTE_ON, 4'hF}, 7'd124, 7'd1));
    endtask

    task automatic test_controller_levels();
        send_word(mk(1'b0, PKT_FULL, {MSG_CC, 4'h0}, 7'd0, 7'd127));
        send_word(mk(1'b0, PKT_FULL, {MSG_CC, 4'h0}, 7'd1, 7'd1));
        send_word(mk(1'b0, PKT_FULL, {MSG_CC, 4'h0}, 7'd0, 7'd0));
        send_word(mk(1'b0, PKT_FULL, {MSG_CC, 4'h0}, 7'd5, 7'd50));
        send_word(mk(1'b0, PKT_FULL, 8'hA0, 7'd1, 7'd99));
        send_word(mk(1'b0, PKT_FULL, 8'hF0, 7'd0, 7'd99));
        send_word(mk(1'b0, PKT_FULL, 8'h00, 7'd0, 7'd99));
    endtask

    task automatic test_shared_controller();
        set_registers(4'd15, 7'd127, 7'd127);
        send_word(mk(1'b0, PKT_FULL, {MSG_CC, 4'hF}, 7'd127, 7'd100));
        send_word(mk(1'b0, PKT_FULL, {MSG_CC, 4'hE}, 7'd127, 7'd3));
    endtask

    task automatic test_random_traffic(int words, int send_pct, int recv_pct,
                                       logic [3:0] chan, logic [6:0] ctrl_a,
                                       logic [6:0] ctrl_b);
        set_registers(chan, ctrl_a, ctrl_b);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (words) send_word(random_word());
        drain();
    endtask

    // result checker and receiver back-pressure
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (decoded_q.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %0d %0d %0d %0d",
                         $time, o_first_level, o_second_level, o_current_note, o_any_held);
                error_count++;
            end else begin
                head_word = decoded_q.pop_front();
                check_field("first_level", 32'(head_word.first_level), 32'(o_first_level));
                check_field("second_level", 32'(head_word.second_level), 32'(o_second_level));
                check_field("current_note", 32'(head_word.current_note), 32'(o_current_note));
                check_field("any_held", 32'(head_word.any_held), 32'(o_any_held));
            end
        end
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("midi_note_priority_cc_decoder_top test failed");
        $finish;
    end

    initial begin
        i_rst_n          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        i_in_valid       = 1'b0;
        i_command        = 1'b0;
        i_packet_length  = '0;
        i_status_byte    = '0;
        i_data_first     = '0;
        i_data_second    = '0;
        i_out_ready      = 1'b0;
        error_count      = 0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        mdl_held         = '0;
        mdl_first_level  = '0;
        mdl_second_level = '0;
        mdl_note         = '0;
        cfg_channel      = '0;
        cfg_first_ctrl   = '0;
        cfg_second_ctrl  = SECOND_CTRL_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_controller_levels();
        test_note_priority();
        test_shared_controller();
        test_random_traffic(285, 0, 0, 4'd15, 7'd127, 7'd126);
        test_random_traffic(285, 56, 0, 4'd3, 7'd64, 7'd64);
        test_random_traffic(285, 0, 56, 4'd0, 7'd0, 7'd127);
        test_random_traffic(285, 19, 19, 4'($urandom), 7'($urandom), 7'($urandom));
        test_random_traffic(285, 56, 56, 4'd9, 7'd5, 7'd5);
        test_random_traffic(285, 19, 19, 4'd15, 7'd0, 7'd0);

        if (error_count == 0) begin
            $display("midi_note_priority_cc_decoder_top test passed");
        end else begin
            $display("midi_note_priority_cc_decoder_top test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
